// ===== hdl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants for the cycle counter time splitter.
// ----------------------------------------------------------------------------
package cct_pkg;

	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned TOTAL_W   = 64;
	localparam int unsigned SEC_W     = 45;
	localparam int unsigned PART_W    = 10;
	localparam int unsigned MHZ_W     = 10;
	localparam int unsigned DIVISOR_W = 30;
	localparam int unsigned REM_W     = 30;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned SEC_LO_W  = 23;
	localparam int unsigned SEC_HI_W  = SEC_W - SEC_LO_W;
	localparam int unsigned PAD_W     = 7;
	localparam int unsigned OUT_DATA_W = 2 * TOTAL_W + SEC_W + 2 * PART_W + PAD_W;

	// quotient bits produced per division
	localparam int unsigned SEC_STEPS = 64;
	localparam int unsigned SUB_STEPS = 10;

	localparam logic [MHZ_W-1:0] MHZ_RESET = 10'd168;
	localparam logic [MHZ_W-1:0] MHZ_MIN   = 10'd1;
	localparam logic [19:0]      US_PER_SEC = 20'd1000000;
	localparam logic [9:0]       US_PER_MS  = 10'd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_SEC,
		ST_DIV_SEC,
		ST_LD_MS,
		ST_DIV_MS,
		ST_LD_US,
		ST_DIV_US,
		ST_MUL_SUB,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MS,
		PH_US
	} phase_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_SUB,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	typedef struct packed {
		logic    ready;
		logic    div_load;
		logic    div_step;
		phase_t  phase;
		mul_op_t mul_op;
		logic    out_write;
	} ctrl_t;

endpackage

// ===== hdl/cct_divider.sv =====
// ----------------------------------------------------------------------------
// cct_divider
// Shared restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module cct_divider
	import cct_pkg::*;
(
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic [REM_W-1:0]     load_rem,
	input  logic [TOTAL_W-1:0]   load_dq,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [REM_W-1:0]     rem,
	output logic [TOTAL_W-1:0]   dq
);

	logic [REM_W-1:0]   rem_q;
	logic [TOTAL_W-1:0] dq_q;
	logic [REM_W:0]     trial;
	logic               fits;
	logic [REM_W-1:0]   rem_next;

	// partial remainder shifted left by one dividend bit
	assign trial = {rem_q, dq_q[TOTAL_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_comb begin
		if (fits) begin
			rem_next = REM_W'(trial - {1'b0, divisor});
		end else begin
			rem_next = trial[REM_W-1:0];
		end
	end

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= load_rem;
			dq_q  <= load_dq;
		end else if (step) begin
			rem_q <= rem_next;
			dq_q  <= {dq_q[TOTAL_W-2:0], fits};
		end
	end

	assign rem = rem_q;
	assign dq  = dq_q;

endmodule

// ===== hdl/cct_ctrl.sv =====
// ----------------------------------------------------------------------------
// cct_ctrl
// Sequencer: loads and steps the divider, then runs the multiply steps.
// ----------------------------------------------------------------------------
module cct_ctrl
	import cct_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_accept,
	input  logic  out_free,
	output ctrl_t ctrl
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_sec;
	logic             last_sub;

	assign last_sec = cnt_q == CNT_W'(SEC_STEPS - 1);
	assign last_sub = cnt_q == CNT_W'(SUB_STEPS - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_LD_SEC;
			end
			ST_LD_SEC:  state_d = ST_DIV_SEC;
			ST_DIV_SEC: begin
				if (last_sec) state_d = ST_LD_MS;
			end
			ST_LD_MS:   state_d = ST_DIV_MS;
			ST_DIV_MS: begin
				if (last_sub) state_d = ST_LD_US;
			end
			ST_LD_US:   state_d = ST_DIV_US;
			ST_DIV_US: begin
				if (last_sub) state_d = ST_MUL_SUB;
			end
			ST_MUL_SUB: state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{ready: 1'b0, div_load: 1'b0, div_step: 1'b0, phase: PH_SEC,
			mul_op: MUL_NONE, out_write: 1'b0};
		case (state_q)
			ST_IDLE:    ctrl.ready = 1'b1;
			ST_LD_SEC:  ctrl.div_load = 1'b1;
			ST_DIV_SEC: ctrl.div_step = 1'b1;
			ST_LD_MS: begin
				ctrl.div_load = 1'b1;
				ctrl.phase    = PH_MS;
			end
			ST_DIV_MS: begin
				ctrl.div_step = 1'b1;
				ctrl.phase    = PH_MS;
			end
			ST_LD_US: begin
				ctrl.div_load = 1'b1;
				ctrl.phase    = PH_US;
			end
			ST_DIV_US: begin
				ctrl.div_step = 1'b1;
				ctrl.phase    = PH_US;
			end
			ST_MUL_SUB: ctrl.mul_op = MUL_SUB;
			ST_MUL_LO:  ctrl.mul_op = MUL_LO;
			ST_MUL_HI:  ctrl.mul_op = MUL_HI;
			ST_DONE:    ctrl.out_write = out_free;
			default:    ctrl.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.div_load) begin
				cnt_q <= '0;
			end else if (ctrl.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/cycle_counter_time_splitter.sv =====
// ----------------------------------------------------------------------------
// cycle_counter_time_splitter
// Extends a 32-bit cycle counter sample with a wrap count and splits the
// 64-bit total into seconds, milliseconds, microseconds and total microseconds.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  counter_sample
//  m_axis    out  m_axis_tvalid/m_axis_tready  time fields, wrap_seen in tuser
//  cfg       in   cfg_we                       clock_mhz
//
//  after acceptance the sequencer loads and steps the shared divider for
//  seconds, then for ms and then for us, runs the MUL_SUB, MUL_LO and MUL_HI
//  multiply-accumulate steps for total microseconds and then writes the
//  output register, where the result sits; if it is still held downstream the
//  sequencer waits in its last state before taking the next item
//  reset clears the wrap count, the previous sample and sets clock_mhz to 168
//
module cycle_counter_time_splitter
	import cct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] counter_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [63:0] total_cycles, [108:64] whole_seconds, [118:109] milliseconds_part,
	// [128:119] microseconds_part, [192:129] total_microseconds, [199:193] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser,   // [0] wrap_seen
	input  logic                  cfg_we,
	input  logic [MHZ_W-1:0]      cfg_wdata        // clock_mhz
);

	ctrl_t ctrl;

	logic in_accept;
	logic out_free;

	// architectural state
	logic [MHZ_W-1:0]    clock_mhz_q;
	logic [SAMPLE_W-1:0] wrap_q;
	logic [SAMPLE_W-1:0] prev_q;

	// per item working registers
	logic [TOTAL_W-1:0]   total_q;
	logic                 wrap_seen_q;
	logic [MHZ_W-1:0]     mhz_q;
	logic [DIVISOR_W-1:0] d1_q;
	logic [19:0]          d2_q;
	logic [SEC_W-1:0]     secs_q;
	logic [PART_W-1:0]    ms_q;
	logic [PART_W-1:0]    us_q;
	logic [TOTAL_W-1:0]   acc_q;

	// output register
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;
	logic                  out_valid_q;

	logic                 wrapped;
	logic [SAMPLE_W-1:0]  wrap_next;
	logic [REM_W-1:0]     div_rem;
	logic [TOTAL_W-1:0]   div_dq;
	logic [REM_W-1:0]     load_rem;
	logic [TOTAL_W-1:0]   load_dq;
	logic [DIVISOR_W-1:0] divisor;
	logic [19:0]          sub_prod;
	logic [42:0]          lo_prod;
	logic [41:0]          hi_prod;

	assign s_axis_tready = ctrl.ready;
	assign in_accept     = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign wrapped   = s_axis_tdata < prev_q;
	assign wrap_next = wrap_q + SAMPLE_W'(wrapped);

	cct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	// seconds divide the whole total; ms and us divide the remainder left
	// by the step before, whose upper bits already sit below the new divisor
	always_comb begin
		case (ctrl.phase)
			PH_SEC: begin
				load_rem = '0;
				load_dq  = total_q;
				divisor  = d1_q;
			end
			PH_MS: begin
				load_rem = div_rem >> PART_W;
				load_dq  = {div_rem[PART_W-1:0], (TOTAL_W - PART_W)'(0)};
				divisor  = DIVISOR_W'(d2_q);
			end
			PH_US: begin
				load_rem = div_rem >> PART_W;
				load_dq  = {div_rem[PART_W-1:0], (TOTAL_W - PART_W)'(0)};
				divisor  = DIVISOR_W'(mhz_q);
			end
			default: begin
				load_rem = '0;
				load_dq  = total_q;
				divisor  = d1_q;
			end
		endcase
	end

	cct_divider u_divider (
		.clk      (clk),
		.load     (ctrl.div_load),
		.step     (ctrl.div_step),
		.load_rem (load_rem),
		.load_dq  (load_dq),
		.divisor  (divisor),
		.rem      (div_rem),
		.dq       (div_dq)
	);

	// total microseconds built as ms*1000 + us, then the two halves of secs*1e6
	assign sub_prod = 20'(ms_q) * 20'(US_PER_MS);
	assign lo_prod  = 43'(secs_q[SEC_LO_W-1:0]) * 43'(US_PER_SEC);
	assign hi_prod  = 42'(secs_q[SEC_W-1:SEC_LO_W]) * 42'(US_PER_SEC);

	// configuration and wrap tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mhz_q <= MHZ_RESET;
			wrap_q      <= '0;
			prev_q      <= '0;
		end else begin
			if (cfg_we) begin
				clock_mhz_q <= cfg_wdata;
			end
			if (in_accept) begin
				wrap_q <= wrap_next;
				prev_q <= s_axis_tdata;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			total_q     <= {wrap_next, s_axis_tdata};
			wrap_seen_q <= wrapped;
			// a zero clock is taken as 1 MHz
			mhz_q       <= (clock_mhz_q == '0) ? MHZ_MIN : clock_mhz_q;
		end
		if (ctrl.div_load && ctrl.phase == PH_SEC) begin
			d1_q <= DIVISOR_W'(mhz_q) * DIVISOR_W'(US_PER_SEC);
			d2_q <= 20'(mhz_q) * 20'(US_PER_MS);
		end
		if (ctrl.div_load && ctrl.phase == PH_MS) begin
			secs_q <= div_dq[SEC_W-1:0];
		end
		if (ctrl.div_load && ctrl.phase == PH_US) begin
			ms_q <= div_dq[PART_W-1:0];
		end
		case (ctrl.mul_op)
			MUL_SUB: begin
				us_q  <= div_dq[PART_W-1:0];
				acc_q <= TOTAL_W'(sub_prod) + TOTAL_W'(div_dq[PART_W-1:0]);
			end
			MUL_LO:  acc_q <= acc_q + TOTAL_W'(lo_prod);
			MUL_HI:  acc_q <= acc_q + TOTAL_W'({hi_prod, SEC_LO_W'(0)});
			default: acc_q <= acc_q;
		endcase
		if (ctrl.out_write) begin
			out_data_q <= {PAD_W'(0), acc_q, us_q, ms_q, secs_q, total_q};
			out_user_q <= wrap_seen_q;
		end
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_write) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// remainder entering every divider step stays below the divisor
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div_step |-> div_rem < divisor)
		else $error("divider remainder not below divisor");

	// the parts of a second delivered are always below one thousand
	a_parts_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[118:109] < 10'd1000)
			&& (m_axis_tdata[128:119] < 10'd1000))
		else $error("millisecond or microsecond part out of range");

	// a freshly accepted item never produces its result on the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !$rose(m_axis_tvalid))
		else $error("result appeared one cycle after acceptance");

	// nothing is accepted while the divider works
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.div_step || ctrl.div_load) |-> !s_axis_tready)
		else $error("input ready while divider busy");

endmodule
